>>> sv/sha_pkg.sv
// ----------------------------------------------------------------------------
// SHA-256 stream hasher package
// Shared constants, types and round functions for the hasher front end,
// block queue and compression core.
// ----------------------------------------------------------------------------
package sha_pkg;

    localparam int WORD_W          = 32;
    localparam int BLOCK_W         = 512;
    localparam int BLOCK_WORDS     = BLOCK_W / WORD_W;
    localparam int DIGEST_WORDS    = 8;
    localparam int COUNT_W         = 61;
    localparam int LENGTH_W        = 64;
    localparam int QUEUE_DEPTH_DEF = 2;

    localparam logic [5:0] LENGTH_POS = 6'd56;
    localparam logic [5:0] LAST_POS   = 6'd63;
    localparam logic [5:0] LAST_ROUND = 6'd63;
    localparam logic [7:0] PAD_BYTE   = 8'h80;

    // One complete 64-byte block and whether it closes a message.
    typedef struct packed {
        logic [BLOCK_W-1:0] data;
        logic               last;
    } blk_entry_t;

    // Status of the block queue seen by both of its neighbors.
    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    typedef enum logic [1:0] {
        FR_DATA,
        FR_PAD,
        FR_LEN
    } front_state_t;

    typedef enum logic [1:0] {
        CO_IDLE,
        CO_ROUND,
        CO_FINISH
    } core_state_t;

    // Initial chaining value, one word per index.
    function automatic logic [WORD_W-1:0] iv_word(input logic [2:0] idx);
        logic [WORD_W-1:0] w;
        unique case (idx)
            3'd0: w = 32'h6a09e667;
            3'd1: w = 32'hbb67ae85;
            3'd2: w = 32'h3c6ef372;
            3'd3: w = 32'ha54ff53a;
            3'd4: w = 32'h510e527f;
            3'd5: w = 32'h9b05688c;
            3'd6: w = 32'h1f83d9ab;
            3'd7: w = 32'h5be0cd19;
            default: w = '0;
        endcase
        return w;
    endfunction

    // Round constants.
    function automatic logic [WORD_W-1:0] round_k(input logic [5:0] idx);
        logic [WORD_W-1:0] k;
        unique case (idx)
            6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
            6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
            6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
            6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
            6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
            6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7;  6'd63: k = 32'hc67178f2;
            default: k = '0;
        endcase
        return k;
    endfunction

    function automatic logic [WORD_W-1:0] big_sigma0(input logic [WORD_W-1:0] x);
        return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic logic [WORD_W-1:0] big_sigma1(input logic [WORD_W-1:0] x);
        return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    function automatic logic [WORD_W-1:0] small_sigma0(input logic [WORD_W-1:0] x);
        return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    function automatic logic [WORD_W-1:0] small_sigma1(input logic [WORD_W-1:0] x);
        return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
    endfunction

endpackage

>>> sv/sha_front.sv
// ----------------------------------------------------------------------------
// SHA-256 front end
// Accepts message bytes, packs them into 64-byte blocks, appends the padding
// and bit length at the end of a message, and hands full blocks to the queue.
// ----------------------------------------------------------------------------
module sha_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  logic [7:0]          data_byte,
    input  logic                has_byte,
    input  logic                end_of_message,
    input  sha_pkg::q_status_t  q_status,
    output logic                q_push,
    output sha_pkg::blk_entry_t q_wr_data
);
    import sha_pkg::*;

    front_state_t         state_reg, state_next;
    logic [BLOCK_W-1:0]   blk_reg;
    logic [5:0]           fill_reg;
    logic [5:0]           fill_inc;
    logic [COUNT_W-1:0]   count_reg, count_next;
    logic [LENGTH_W-1:0]  len_reg;
    logic [2:0]           len_cnt_reg;
    logic                 pad_first_reg;
    logic                 accept;
    logic                 shift_en;
    logic [7:0]           byte_in;

    assign accept   = push && !full;
    assign fill_inc = fill_reg + 6'd1;

    // The count including this item's byte, used to build the bit length.
    assign count_next = count_reg + {{(COUNT_W-1){1'b0}}, has_byte};

    // Outputs: which byte enters the block this cycle.
    always_comb
    begin
        full     = (state_reg != FR_DATA) || q_status.full;
        shift_en = 1'b0;
        byte_in  = data_byte;
        unique case (state_reg)
            FR_DATA:
            begin
                shift_en = accept && has_byte;
                byte_in  = data_byte;
            end
            FR_PAD:
            begin
                shift_en = !q_status.full;
                byte_in  = pad_first_reg ? PAD_BYTE : 8'h00;
            end
            FR_LEN:
            begin
                shift_en = !q_status.full;
                byte_in  = len_reg[LENGTH_W-1 -: 8];
            end
            default:
            begin
                shift_en = 1'b0;
                byte_in  = data_byte;
            end
        endcase
        q_push         = shift_en && (fill_reg == LAST_POS);
        q_wr_data.data = {blk_reg[BLOCK_W-9:0], byte_in};
        q_wr_data.last = (state_reg == FR_LEN);
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            FR_DATA:
            begin
                if (accept && end_of_message)
                begin
                    state_next = FR_PAD;
                end
            end
            FR_PAD:
            begin
                if (shift_en && (fill_inc == LENGTH_POS))
                begin
                    state_next = FR_LEN;
                end
            end
            FR_LEN:
            begin
                if (shift_en && (len_cnt_reg == 3'd7))
                begin
                    state_next = FR_DATA;
                end
            end
            default:
            begin
                state_next = FR_DATA;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= FR_DATA;
            fill_reg      <= '0;
            count_reg     <= '0;
            len_cnt_reg   <= '0;
            pad_first_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (shift_en)
            begin
                fill_reg <= fill_inc;
            end
            if (state_reg == FR_DATA && accept)
            begin
                count_reg     <= count_next;
                pad_first_reg <= end_of_message;
                len_cnt_reg   <= '0;
            end
            if (state_reg == FR_PAD && shift_en)
            begin
                pad_first_reg <= 1'b0;
            end
            if (state_reg == FR_LEN && shift_en)
            begin
                len_cnt_reg <= len_cnt_reg + 3'd1;
                if (len_cnt_reg == 3'd7)
                begin
                    count_reg <= '0;
                end
            end
        end
    end

    // Block shift line and length bytes.
    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            blk_reg <= {blk_reg[BLOCK_W-9:0], byte_in};
        end
        if (state_reg == FR_DATA && accept && end_of_message)
        begin
            len_reg <= {count_next, 3'b000};
        end
        else if (state_reg == FR_LEN && shift_en)
        begin
            len_reg <= {len_reg[LENGTH_W-9:0], 8'h00};
        end
    end

endmodule

>>> sv/sha_queue.sv
// ----------------------------------------------------------------------------
// SHA-256 block queue
// A short first-in first-out queue of complete blocks between the front end
// and the compression core.
// ----------------------------------------------------------------------------
module sha_queue #(
    parameter int DEPTH = sha_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  sha_pkg::blk_entry_t wr_data,
    input  logic                pop,
    output sha_pkg::blk_entry_t rd_data,
    output sha_pkg::q_status_t  status
);
    import sha_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    blk_entry_t       entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             do_push, do_pop;

    assign status.full  = (cnt_reg == CNT_W'(DEPTH));
    assign status.empty = (cnt_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign rd_data      = entry_reg[rd_ptr_reg];

    // Pointers and occupancy.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

>>> sv/sha_core.sv
// ----------------------------------------------------------------------------
// SHA-256 compression core
// Runs one compression round per cycle on each queued block, keeps the
// chaining words and presents the digest words one transfer at a time.
// ----------------------------------------------------------------------------
module sha_core (
    input  logic                clk,
    input  logic                rst_n,
    input  sha_pkg::q_status_t  q_status,
    input  sha_pkg::blk_entry_t q_rd_data,
    output logic                q_pop,
    output logic                empty,
    input  logic                pop,
    output logic [31:0]         digest_word,
    output logic [2:0]          word_index,
    output logic                last_word
);
    import sha_pkg::*;

    core_state_t         state_reg, state_next;
    logic [WORD_W-1:0]   w_reg   [BLOCK_WORDS];
    logic [WORD_W-1:0]   v_reg   [DIGEST_WORDS];
    logic [WORD_W-1:0]   h_reg   [DIGEST_WORDS];
    logic [WORD_W-1:0]   dig_reg [DIGEST_WORDS];
    logic [5:0]          round_reg;
    logic                last_reg;
    logic                out_valid_reg;
    logic [2:0]          idx_reg;
    logic                fin_ok;
    logic                out_pop;
    logic [WORD_W-1:0]   t1, t2, w_new;

    assign out_pop     = pop && out_valid_reg;
    assign empty       = !out_valid_reg;
    assign digest_word = dig_reg[idx_reg];
    assign word_index  = idx_reg;
    assign last_word   = (idx_reg == 3'd7);

    // Outputs of the sequencer.
    always_comb
    begin
        q_pop  = 1'b0;
        fin_ok = 1'b0;
        unique case (state_reg)
            CO_IDLE:   q_pop  = !q_status.empty;
            CO_ROUND:  q_pop  = 1'b0;
            CO_FINISH: fin_ok = !last_reg || !out_valid_reg;
            default:   q_pop  = 1'b0;
        endcase
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            CO_IDLE:
            begin
                if (q_pop)
                begin
                    state_next = CO_ROUND;
                end
            end
            CO_ROUND:
            begin
                if (round_reg == LAST_ROUND)
                begin
                    state_next = CO_FINISH;
                end
            end
            CO_FINISH:
            begin
                if (fin_ok)
                begin
                    state_next = CO_IDLE;
                end
            end
            default:
            begin
                state_next = CO_IDLE;
            end
        endcase
    end

    // One round and the next message schedule word.
    always_comb
    begin
        t1 = v_reg[7] + big_sigma1(v_reg[4])
           + ((v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]))
           + round_k(round_reg) + w_reg[0];
        t2 = big_sigma0(v_reg[0])
           + ((v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]));
        w_new = w_reg[0] + small_sigma0(w_reg[1]) + w_reg[9] + small_sigma1(w_reg[14]);
    end

    // Control registers and chaining words.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= CO_IDLE;
            round_reg     <= '0;
            last_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
            for (int i = 0; i < DIGEST_WORDS; i++)
            begin
                h_reg[i] <= iv_word(3'(i));
            end
        end
        else
        begin
            state_reg <= state_next;
            if (q_pop)
            begin
                round_reg <= '0;
                last_reg  <= q_rd_data.last;
            end
            else if (state_reg == CO_ROUND)
            begin
                round_reg <= round_reg + 6'd1;
            end
            if (state_reg == CO_FINISH && fin_ok)
            begin
                for (int i = 0; i < DIGEST_WORDS; i++)
                begin
                    h_reg[i] <= last_reg ? iv_word(3'(i)) : h_reg[i] + v_reg[i];
                end
            end
            // Digest word transfers; the last one frees the output buffer.
            if (out_pop)
            begin
                idx_reg <= idx_reg + 3'd1;
                if (idx_reg == 3'd7)
                begin
                    out_valid_reg <= 1'b0;
                end
            end
            if (state_reg == CO_FINISH && fin_ok && last_reg)
            begin
                out_valid_reg <= 1'b1;
                idx_reg       <= '0;
            end
        end
    end

    // Working variables, schedule window and digest buffer.
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            for (int i = 0; i < BLOCK_WORDS; i++)
            begin
                w_reg[i] <= q_rd_data.data[BLOCK_W-1-WORD_W*i -: WORD_W];
            end
            for (int i = 0; i < DIGEST_WORDS; i++)
            begin
                v_reg[i] <= h_reg[i];
            end
        end
        else if (state_reg == CO_ROUND)
        begin
            for (int i = 0; i < BLOCK_WORDS - 1; i++)
            begin
                w_reg[i] <= w_reg[i+1];
            end
            w_reg[BLOCK_WORDS-1] <= w_new;
            v_reg[7] <= v_reg[6];
            v_reg[6] <= v_reg[5];
            v_reg[5] <= v_reg[4];
            v_reg[4] <= v_reg[3] + t1;
            v_reg[3] <= v_reg[2];
            v_reg[2] <= v_reg[1];
            v_reg[1] <= v_reg[0];
            v_reg[0] <= t1 + t2;
        end
        if (state_reg == CO_FINISH && fin_ok && last_reg)
        begin
            for (int i = 0; i < DIGEST_WORDS; i++)
            begin
                dig_reg[i] <= h_reg[i] + v_reg[i];
            end
        end
    end

endmodule

>>> sv/sha256_stream_hasher.sv
// Throughput: one byte per cycle while the front end is taking data bytes and the
// block queue has room; each block occupies the one-round-per-cycle compression core.
// Reset: chaining words return to the initial hash value, the block queue is empty.
// ----------------------------------------------------------------------------
// SHA-256 stream hasher
// Byte-serial SHA-256 with a packing front end, a block queue and a
// compression core that emits the eight digest words of each message.
// ----------------------------------------------------------------------------
module sha256_stream_hasher #(
    parameter int QUEUE_DEPTH = sha_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  data_byte,
    input  logic        has_byte,
    input  logic        end_of_message,
    output logic        empty,
    input  logic        pop,
    output logic [31:0] digest_word,
    output logic [2:0]  word_index,
    output logic        last_word
);
    import sha_pkg::*;

    blk_entry_t q_wr_data, q_rd_data;
    q_status_t  q_status;
    logic       q_push, q_pop;

    // Byte packing and padding.
    sha_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .data_byte      (data_byte),
        .has_byte       (has_byte),
        .end_of_message (end_of_message),
        .q_status       (q_status),
        .q_push         (q_push),
        .q_wr_data      (q_wr_data)
    );

    // Block queue between the two halves.
    sha_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (q_push),
        .wr_data (q_wr_data),
        .pop     (q_pop),
        .rd_data (q_rd_data),
        .status  (q_status)
    );

    // Compression and digest output.
    sha_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_status    (q_status),
        .q_rd_data   (q_rd_data),
        .q_pop       (q_pop),
        .empty       (empty),
        .pop         (pop),
        .digest_word (digest_word),
        .word_index  (word_index),
        .last_word   (last_word)
    );

    // A finished block is never offered to a full queue.
    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_status.full)
        else $error("block handed to a full queue");

    // The input side stalls whenever the block queue is full.
    a_full_follows_queue: assert property (@(posedge clk) disable iff (!rst_n)
        q_status.full |-> full)
        else $error("input accepted with the block queue full");

    // Taking the last digest word empties the output until the next digest.
    a_last_word_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !empty && last_word) |=> empty)
        else $error("output still busy after the last digest word");

endmodule
